[design/csdi_pkg.sv]
// Package for the charge state debounce indicator.
// Holds the payload structs, mode and status codes, colours and field widths.
// Depends on nothing; every other file imports it.
`timescale 1ns / 1ps

package csdi_pkg;

  // Width of the consecutive-sample counter.
  localparam int COUNT_BITS = 8;

  localparam int CFG_DATA_W = 10;
  localparam int CFG_IDX_W  = 2;
  localparam int COMMIT_W   = 8;
  localparam int CMP_W      = (COUNT_BITS > COMMIT_W) ? COUNT_BITS : COMMIT_W;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_DEADBAND = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COMMIT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_SOC  = 2'd2;

  // Committed modes.
  localparam logic [1:0] MODE_IDLE      = 2'd0;
  localparam logic [1:0] MODE_CHARGE    = 2'd1;
  localparam logic [1:0] MODE_DISCHARGE = 2'd2;

  // Status chip codes.
  localparam logic [1:0] CHIP_STANDBY   = 2'd0;
  localparam logic [1:0] CHIP_CHARGING  = 2'd1;
  localparam logic [1:0] CHIP_DISCHARGE = 2'd2;
  localparam logic [1:0] CHIP_LOW       = 2'd3;

  // RGB565 colours.
  localparam logic [15:0] COLOR_GREEN = 16'h2E4F;
  localparam logic [15:0] COLOR_AMBER = 16'hF524;
  localparam logic [15:0] COLOR_BLUE  = 16'h349E;
  localparam logic [15:0] COLOR_RED   = 16'hEA48;

  typedef struct packed {
    logic [6:0]         soc_percent;
    logic signed [15:0] current_deci_amps;
  } in_item_t;

  typedef struct packed {
    logic [6:0]  charge_value;
    logic [15:0] indicator_color;
    logic [1:0]  status_chip;
    logic [1:0]  shown_mode;
  } out_item_t;

endpackage

[design/charge_state_debounce_indicator.sv]
// Top level of the charge state debounce indicator.
// Classifier, debounce counter, colour selection and result register.
// Depends on csdi_pkg.
`timescale 1ns / 1ps

// Takes one sample per cycle and gives one result per sample in the cycle after
// the transfer. The whole classify, debounce and colour decision is done in a
// single pass of logic into the result register, so samples may follow each
// other on every clock; in_ready falls only while a result waits unaccepted.
// The current is compared against a symmetric deadband; a class other than
// the committed mode must be seen on commit_count consecutive samples before
// it is committed. shown_mode and the colour reflect the mode after the
// sample. Configuration writes take effect on the next sample.
module charge_state_debounce_indicator
  import csdi_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
  localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);

  logic [9:0]            deadband;
  logic [COMMIT_W-1:0]   commit_count;
  logic [6:0]            low_soc;

  logic [1:0]            active_mode, active_mode_next;
  logic [1:0]            candidate_mode, candidate_mode_next;
  logic                  candidate_valid, candidate_valid_next;
  logic [COUNT_BITS-1:0] run_count, run_count_next;

  logic                  in_fire;
  logic signed [16:0]    cur_ext, band_pos, band_neg;
  logic [1:0]            cls;
  logic [COUNT_BITS-1:0] run_inc;
  out_item_t             result;

  assign in_ready = !out_valid || out_ready;
  assign in_fire  = in_valid && in_ready;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      deadband     <= 10'd3;
      commit_count <= 8'd30;
      low_soc      <= 7'd20;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DEADBAND: deadband     <= cfg_data;
        REG_COMMIT:   commit_count <= cfg_data[COMMIT_W-1:0];
        REG_LOW_SOC:  low_soc      <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // Deadband classification, exact and signed.
  always_comb begin
    cur_ext  = 17'(in_data.current_deci_amps);
    band_pos = $signed({7'd0, deadband});
    band_neg = -band_pos;
    if (cur_ext > band_pos) begin
      cls = MODE_CHARGE;
    end else if (cur_ext < band_neg) begin
      cls = MODE_DISCHARGE;
    end else begin
      cls = MODE_IDLE;
    end
  end

  // Debounce: count consecutive samples of a class other than the committed one.
  always_comb begin
    active_mode_next     = active_mode;
    candidate_mode_next  = candidate_mode;
    candidate_valid_next = candidate_valid;
    run_count_next       = run_count;
    run_inc              = COUNT_ONE;
    if (cls == active_mode) begin
      run_count_next       = '0;
      candidate_valid_next = 1'b0;
      candidate_mode_next  = MODE_IDLE;
    end else begin
      if (candidate_valid && cls == candidate_mode) begin
        run_inc = (run_count == COUNT_MAX) ? run_count : run_count + COUNT_ONE;
      end
      run_count_next       = run_inc;
      candidate_mode_next  = cls;
      candidate_valid_next = 1'b1;
      if (CMP_W'(run_inc) >= CMP_W'(commit_count)) begin
        active_mode_next     = cls;
        run_count_next       = '0;
        candidate_valid_next = 1'b0;
        candidate_mode_next  = MODE_IDLE;
      end
    end
  end

  // Colour and status chip from the mode after this sample.
  always_comb begin
    result.charge_value = in_data.soc_percent;
    result.shown_mode   = active_mode_next;
    unique case (active_mode_next)
      MODE_CHARGE: begin
        result.indicator_color = COLOR_GREEN;
        result.status_chip     = CHIP_CHARGING;
      end
      MODE_DISCHARGE: begin
        if (in_data.soc_percent <= low_soc) begin
          result.indicator_color = COLOR_RED;
          result.status_chip     = CHIP_LOW;
        end else begin
          result.indicator_color = COLOR_BLUE;
          result.status_chip     = CHIP_DISCHARGE;
        end
      end
      default: begin
        result.indicator_color = COLOR_AMBER;
        result.status_chip     = CHIP_STANDBY;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active_mode     <= MODE_IDLE;
      candidate_mode  <= MODE_IDLE;
      candidate_valid <= 1'b0;
      run_count       <= '0;
      out_valid       <= 1'b0;
    end else begin
      if (in_fire) begin
        active_mode     <= active_mode_next;
        candidate_mode  <= candidate_mode_next;
        candidate_valid <= candidate_valid_next;
        run_count       <= run_count_next;
        out_valid       <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data <= result;
    end
  end

endmodule

[design/csdi_checker.sv]
// Port-level checker for the charge state debounce indicator.
// Bound to the top level below; depends on csdi_pkg.
`timescale 1ns / 1ps

module csdi_checker
  import csdi_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      in_valid,
  input logic      in_ready,
  input in_item_t  in_data,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  // A waiting result must hold until its transfer.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed or dropped while stalled");

  // The single result register blocks new samples while it is stalled.
  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("sample taken while result register is full");

  // Each accepted sample yields a result with its charge passed through.
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> out_valid && out_data.charge_value == $past(in_data.soc_percent))
    else $error("result missing or charge value wrong");

  // Colour and chip agree with the shown mode.
  a_colour_mode: assert property (@(posedge clk) disable iff (rst)
    out_valid |->
      (out_data.shown_mode == MODE_CHARGE && out_data.status_chip == CHIP_CHARGING &&
       out_data.indicator_color == COLOR_GREEN) ||
      (out_data.shown_mode == MODE_IDLE && out_data.status_chip == CHIP_STANDBY &&
       out_data.indicator_color == COLOR_AMBER) ||
      (out_data.shown_mode == MODE_DISCHARGE && out_data.status_chip == CHIP_DISCHARGE &&
       out_data.indicator_color == COLOR_BLUE) ||
      (out_data.shown_mode == MODE_DISCHARGE && out_data.status_chip == CHIP_LOW &&
       out_data.indicator_color == COLOR_RED))
    else $error("colour or chip does not match shown mode");

  // No result straight after reset.
  a_reset_empty: assert property (@(posedge clk) disable iff (rst) $past(rst) |-> !out_valid)
    else $error("result valid after reset");

endmodule

bind charge_state_debounce_indicator csdi_checker u_csdi_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
